[rtl/rfdt_pkg.sv]
// Package for the ring fault diagnosis table.
// Holds node sizes, event and result codes, entry state codes, request type
// and small ring helper functions. No dependencies.
package rfdt_pkg;

  localparam int NODE_W    = 4;
  localparam int RING_W    = NODE_W + 1;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int MAX_NODES = 1 << NODE_W;
  localparam int MIN_NODES = 2;
  localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;

  localparam logic [RING_W-1:0] RING_MAX = RING_W'(MAX_NODES);
  localparam logic [RING_W-1:0] RING_MIN = RING_W'(MIN_NODES);

  // Event codes on the input
  localparam logic [1:0] KIND_TEST    = 2'd0;
  localparam logic [1:0] KIND_FAULT   = 2'd1;
  localparam logic [1:0] KIND_RECOVER = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // Result codes
  localparam logic [1:0] RK_TEST   = 2'd0;
  localparam logic [1:0] RK_VECTOR = 2'd1;
  localparam logic [1:0] RK_ACK    = 2'd2;
  localparam logic [1:0] RK_SKIP   = 2'd3;

  // Diagnosis entry states
  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_ONLINE  = 2'd1;
  localparam logic [1:0] ST_OFFLINE = 2'd2;

  // One queued request between front and back
  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] node;
  } req_t;

  // Clamp a written ring size to the supported range
  function automatic logic [RING_W-1:0] ring_sat(input logic [RING_W-1:0] v);
    logic [RING_W-1:0] r;
    r = v;
    if (v < RING_MIN) r = RING_MIN;
    if (v > RING_MAX) r = RING_MAX;
    return r;
  endfunction

  // Successor of a node on a ring of n nodes
  function automatic logic [NODE_W-1:0] next_node(input logic [NODE_W-1:0] cur,
                                                  input logic [RING_W-1:0] n);
    logic [RING_W-1:0] inc;
    inc = {1'b0, cur} + RING_W'(1);
    return (inc == n) ? '0 : inc[NODE_W-1:0];
  endfunction

endpackage

[rtl/rfdt_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module rfdt_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/rfdt_front.sv]
// Front end: accepts event requests, drops those that cause no result and
// queues the rest for the back end. Depends on rfdt_pkg.
module rfdt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [rfdt_pkg::NODE_W-1:0]   in_node,
  input  logic [rfdt_pkg::RING_W-1:0]   ring_n,
  output logic                          req_valid,
  output rfdt_pkg::req_t                req,
  input  logic                          req_pop
);

  rfdt_pkg::req_t q_mem_r [2];
  logic           wptr_r;
  logic           rptr_r;
  logic [1:0]     count_r;
  logic           keep;
  logic           push;

  // Unused kind and nodes outside the ring produce nothing
  assign keep = (in_kind != rfdt_pkg::KIND_UNUSED) && ({1'b0, in_node} < ring_n);
  assign busy = (count_r == 2'd2);
  assign push = start && !busy && keep;

  assign req_valid = (count_r != 2'd0);
  assign req       = q_mem_r[rptr_r];

  // Two-entry request queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (req_pop) begin
        rptr_r <= ~rptr_r;
      end
      if (push && !req_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && req_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= '{kind: in_kind, node: in_node};
    end
  end

endmodule

[rtl/rfdt_back.sv]
// Back end: holds the faulty flags and diagnosis matrix, runs fault,
// recovery and test requests and drives the result strobe.
// Depends on rfdt_pkg and rfdt_ram.
module rfdt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rfdt_pkg::RING_W-1:0]   ring_n,
  input  logic                          req_valid,
  input  rfdt_pkg::req_t                req,
  output logic                          req_pop,
  output logic                          out_valid,
  output logic [1:0]                    out_result_kind,
  output logic [rfdt_pkg::NODE_W-1:0]   out_subject,
  output logic [1:0]                    out_subject_state,
  output logic                          out_error,
  output logic                          out_last
);

  localparam int NW = rfdt_pkg::NODE_W;
  localparam int AW = rfdt_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WALK, S_COPY, S_COPY_END, S_EMIT, S_EMIT_END
  } state_t;

  state_t                    state_r;
  logic [1:0]                kind_r;
  logic [NW-1:0]             node_r;
  logic [NW-1:0]             nx_r;
  logic [NW-1:0]             col_r;
  logic [NW-1:0]             step_r;
  logic                      cp_pend_r;
  logic [NW-1:0]             cp_col_r;
  logic                      em_pend_r;
  logic [NW-1:0]             em_col_r;
  logic                      em_last_r;
  logic [rfdt_pkg::MAX_NODES-1:0] faulty_r;
  logic [rfdt_pkg::MAT_DEPTH-1:0] valid_r;
  logic [NW-1:0]             rd_row_r;
  logic [NW-1:0]             rd_col_r;
  logic                      rd_vld_r;

  logic                      out_valid_r;
  logic [1:0]                out_kind_r;
  logic [NW-1:0]             out_subject_r;
  logic [1:0]                out_state_r;
  logic                      out_error_r;
  logic                      out_last_r;

  logic [NW-1:0]             flag_addr;
  logic                      flag;
  logic [NW-1:0]             col_inc;
  logic [NW-1:0]             nx_inc;
  logic                      walk_end;
  logic                      col_end;
  logic [AW-1:0]             raddr;
  logic [1:0]                ram_q;
  logic [1:0]                rd_fix;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [1:0]                wdata;

  // Faulty flag lookup: walk position during a walk, else the request node
  assign flag_addr = (state_r == S_WALK) ? nx_r : node_r;
  assign flag      = faulty_r[flag_addr];

  assign col_inc  = rfdt_pkg::next_node(col_r, ring_n);
  assign nx_inc   = rfdt_pkg::next_node(nx_r, ring_n);
  assign walk_end = ({1'b0, step_r} + rfdt_pkg::RING_W'(1)) == ring_n;
  assign col_end  = ({1'b0, col_r} + rfdt_pkg::RING_W'(1)) == ring_n;

  assign req_pop = (state_r == S_IDLE) && req_valid;

  // Matrix read: source row while copying, tester row otherwise
  assign raddr = (state_r == S_COPY) ? {nx_r, col_r} : {node_r, col_r};

  // Entries never written read as their reset value
  assign rd_fix = rd_vld_r ? ram_q :
                  ((rd_row_r == rd_col_r) ? rfdt_pkg::ST_ONLINE : rfdt_pkg::ST_UNKNOWN);

  // Matrix write: walk verdict, or one copied entry in the cycle after its read
  assign we    = (state_r == S_WALK) || cp_pend_r;
  assign waddr = (state_r == S_WALK) ? {node_r, nx_r} : {node_r, cp_col_r};
  assign wdata = (state_r == S_WALK) ?
                 (flag ? rfdt_pkg::ST_OFFLINE : rfdt_pkg::ST_ONLINE) : rd_fix;

  rfdt_ram #(
    .WIDTH (2),
    .DEPTH (rfdt_pkg::MAT_DEPTH)
  ) u_mat (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Side info registered with the RAM read
  always_ff @(posedge clk) begin
    rd_row_r <= raddr[AW-1:NW];
    rd_col_r <= raddr[NW-1:0];
    rd_vld_r <= valid_r[raddr];
  end

  // Sequencer, flags and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cp_pend_r   <= 1'b0;
      em_pend_r   <= 1'b0;
      faulty_r    <= '0;
      valid_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      cp_pend_r   <= 1'b0;
      em_pend_r   <= 1'b0;

      if (we) begin
        valid_r[waddr] <= 1'b1;
      end

      // Vector entry whose read was issued last cycle
      if (em_pend_r) begin
        out_valid_r   <= 1'b1;
        out_kind_r    <= rfdt_pkg::RK_VECTOR;
        out_subject_r <= em_col_r;
        out_state_r   <= rd_fix;
        out_error_r   <= 1'b0;
        out_last_r    <= em_last_r;
      end

      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            kind_r  <= req.kind;
            node_r  <= req.node;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          out_subject_r <= node_r;
          out_error_r   <= 1'b0;
          out_last_r    <= 1'b1;
          state_r       <= S_IDLE;
          case (kind_r)
            rfdt_pkg::KIND_FAULT: begin
              out_valid_r      <= 1'b1;
              out_kind_r       <= rfdt_pkg::RK_ACK;
              out_state_r      <= rfdt_pkg::ST_OFFLINE;
              out_error_r      <= flag;
              faulty_r[node_r] <= 1'b1;
            end
            rfdt_pkg::KIND_RECOVER: begin
              out_valid_r      <= 1'b1;
              out_kind_r       <= rfdt_pkg::RK_ACK;
              out_state_r      <= rfdt_pkg::ST_ONLINE;
              faulty_r[node_r] <= 1'b0;
            end
            rfdt_pkg::KIND_TEST: begin
              if (flag) begin
                out_valid_r <= 1'b1;
                out_kind_r  <= rfdt_pkg::RK_SKIP;
                out_state_r <= rfdt_pkg::ST_OFFLINE;
              end else begin
                nx_r    <= rfdt_pkg::next_node(node_r, ring_n);
                step_r  <= NW'(1);
                state_r <= S_WALK;
              end
            end
            default: ;
          endcase
        end

        // Test one node per cycle around the ring
        S_WALK: begin
          out_valid_r   <= 1'b1;
          out_kind_r    <= rfdt_pkg::RK_TEST;
          out_subject_r <= nx_r;
          out_error_r   <= 1'b0;
          if (flag) begin
            out_state_r <= rfdt_pkg::ST_OFFLINE;
            out_last_r  <= walk_end;
            if (walk_end) begin
              state_r <= S_IDLE;
            end else begin
              nx_r   <= nx_inc;
              step_r <= step_r + NW'(1);
            end
          end else begin
            out_state_r <= rfdt_pkg::ST_ONLINE;
            out_last_r  <= 1'b0;
            if (nx_inc == node_r) begin
              col_r   <= '0;
              state_r <= S_EMIT;
            end else begin
              col_r   <= nx_inc;
              state_r <= S_COPY;
            end
          end
        end

        // Copy entries after the tested node up to the tester
        S_COPY: begin
          cp_pend_r <= 1'b1;
          cp_col_r  <= col_r;
          col_r     <= col_inc;
          if (col_inc == node_r) begin
            state_r <= S_COPY_END;
          end
        end

        S_COPY_END: begin
          col_r   <= '0;
          state_r <= S_EMIT;
        end

        // Read out the tester's vector
        S_EMIT: begin
          em_pend_r <= 1'b1;
          em_col_r  <= col_r;
          em_last_r <= col_end;
          col_r     <= col_inc;
          if (col_end) begin
            state_r <= S_EMIT_END;
          end
        end

        S_EMIT_END: begin
          state_r <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_subject       = out_subject_r;
  assign out_subject_state = out_state_r;
  assign out_error         = out_error_r;
  assign out_last          = out_last_r;

endmodule

[rtl/ring_fault_diagnosis_table_top.sv]
// Top level of the ring fault diagnosis table.
// Depends on rfdt_pkg, rfdt_front and rfdt_back.
//
// Usage:
//   Requests enter on start/in_kind/in_node and are taken at an edge where
//   start is high and busy is low. busy rises only when the two-entry
//   request queue is full. Requests with the unused kind or a node outside
//   the ring are taken and dropped with no result.
//   Results leave on out_* for one cycle each, marked by out_valid; out_last
//   flags the final result of a request. The receiver cannot stall them.
//   cfg_data writes the ring size (clamped to 2..16) on cfg_valid; cfg_ready
//   is always high. Write it only while no request is in flight.
// Operation:
//   Fault and recovery requests go from the queue through S_IDLE and S_EXEC
//   to the result register. A test walks nodes after the tester, copies
//   entries and reads out the vector, all through the one matrix RAM.
//   Requests run one at a time in order; the back end takes a new one only
//   once it is back in S_IDLE.
// Reset: synchronous, active low. All nodes fault free, ring size 16, matrix
//   back to diagonal online, the rest unknown (per-entry valid bits, no sweep).
module ring_fault_diagnosis_table_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_kind,
  input  logic [rfdt_pkg::NODE_W-1:0] in_node,
  output logic                        out_valid,
  output logic [1:0]                  out_result_kind,
  output logic [rfdt_pkg::NODE_W-1:0] out_subject,
  output logic [1:0]                  out_subject_state,
  output logic                        out_error,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rfdt_pkg::RING_W-1:0] cfg_data
);

  logic [rfdt_pkg::RING_W-1:0] ring_n_r;
  logic                        req_valid;
  rfdt_pkg::req_t              req;
  logic                        req_pop;

  // Ring size register, clamped on write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_n_r <= rfdt_pkg::RING_MAX;
    end else if (cfg_valid && cfg_ready) begin
      ring_n_r <= rfdt_pkg::ring_sat(cfg_data);
    end
  end

  rfdt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_kind   (in_kind),
    .in_node   (in_node),
    .ring_n    (ring_n_r),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  rfdt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ring_n            (ring_n_r),
    .req_valid         (req_valid),
    .req               (req),
    .req_pop           (req_pop),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_subject       (out_subject),
    .out_subject_state (out_subject_state),
    .out_error         (out_error),
    .out_last          (out_last)
  );

endmodule

[rtl/rfdt_checker.sv]
// Port-level checks for the ring fault diagnosis table, bound to the top.
// Depends on rfdt_pkg and ring_fault_diagnosis_table_top.
module rfdt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic [1:0]                  out_result_kind,
  input logic [1:0]                  out_subject_state,
  input logic                        out_error,
  input logic                        out_last
);

  // No result right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // Only fault acknowledgements carry the error flag
  a_error_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_result_kind == rfdt_pkg::RK_ACK &&
                               out_subject_state == rfdt_pkg::ST_OFFLINE)
    else $error("error flag on a result that is not a fault ack");

  // Acks and skips are single results of their request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == rfdt_pkg::RK_ACK ||
                  out_result_kind == rfdt_pkg::RK_SKIP) |-> out_last)
    else $error("ack or skip without last");

  // A skipped test reports the tester offline
  a_skip_offline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == rfdt_pkg::RK_SKIP |->
      out_subject_state == rfdt_pkg::ST_OFFLINE)
    else $error("skip result not offline");

  // A request never yields two results in back-to-back cycles after last
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result directly after a last result");

endmodule

bind ring_fault_diagnosis_table_top rfdt_checker u_rfdt_checker (.*);
